@@ rtl/ojq_pkg.sv @@
// Shared types and constants for the ordered job queue with keyed removal.
// Holds field widths, operation and status codes and the control/status structs.
// No dependencies.
package ojq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned JOB_W       = 16;
  localparam int unsigned PROC_W      = 22;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned ENT_W       = JOB_W + PROC_W;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RM_JOB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RM_PROC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              load;
    logic              app;
    logic              clr;
    logic              idx_clr;
    logic              idx_inc;
    logic              rd;
    logic              rd_next;
    logic              hit_cap;
    logic              shift_wr;
    logic              dec;
    logic              st_set;
    logic [STAT_W-1:0] st_val;
    logic              out_load;
  } ojq_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              at_end;
    logic              last;
    logic              hit;
  } ojq_sts_t;

endpackage

@@ rtl/ordered_job_queue_keyed_remove.sv @@
// Ordered job queue with removal by job id or process id.
// Input stream: in_tuser carries the operation (append, pop head, remove by
//   job id, remove by process id, clear); in_tdata the job id and process id.
// Output stream: one transfer per input item with status, removed entry,
//   fill level and empty flag.
// Sequence: append, clear and unused operations go from the decide state
//   straight to the finish state. Pop and removals walk the entry memory
//   through its single registered read port, a read state and then a compare
//   or write state for each entry, over the N entries held, at most QUEUE_DEPTH.
// One item is in work at a time; in_tready is high while the sequencer idles.
// A finished result sits in the output register, so the next input transfer
//   is taken while the receiver stalls; that item then holds in its last
//   step until the output register frees.
// Reset empties the queue at once; entry contents are left as they are and
//   are only read below the fill count.
// Depends on ojq_pkg, ojq_ctrl and ojq_dp.
module ordered_job_queue_keyed_remove #(
  parameter int unsigned QUEUE_DEPTH = ojq_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // job_id [15:0], proc_id [37:16], zero fill
  input  logic [ojq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind [2:0]
  input  logic [ojq_pkg::KIND_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status [1:0], out_job_id [17:2], out_proc_id [39:18], fill_level [44:40],
  // is_empty [45], zero fill
  output logic [ojq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  ojq_pkg::ojq_cmd_t cmd;
  ojq_pkg::ojq_sts_t sts;

  ojq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ojq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_job_id  (in_tdata[15:0]),
    .in_proc_id (in_tdata[37:16]),
    .out_data   (out_tdata)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.full && sts.empty))
    else $error("queue reports full and empty together");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[45]) |-> (out_tdata[44:40] == '0))
    else $error("empty flag with nonzero fill level");

  a_no_removal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == ojq_pkg::ST_NONE || out_tdata[1:0] == ojq_pkg::ST_FULL))
    |-> (out_tdata[39:2] == '0))
    else $error("removed entry reported without a removal");
`endif

endmodule

@@ rtl/ojq_dp.sv @@
// Datapath of the ordered job queue: entry memory, count, scan index,
// operand, result and output payload registers. Depends on ojq_pkg.
module ojq_dp #(
  parameter int unsigned QUEUE_DEPTH = ojq_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ojq_pkg::ojq_cmd_t                  cmd,
  output ojq_pkg::ojq_sts_t                  sts,
  input  logic [ojq_pkg::KIND_W-1:0]         in_kind,
  input  logic [ojq_pkg::JOB_W-1:0]          in_job_id,
  input  logic [ojq_pkg::PROC_W-1:0]         in_proc_id,
  output logic [ojq_pkg::OUT_TDATA_W-1:0]    out_data
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned JW = ojq_pkg::JOB_W;
  localparam int unsigned PW = ojq_pkg::PROC_W;
  localparam int unsigned EW = ojq_pkg::ENT_W;
  localparam int unsigned FW = ojq_pkg::FILL_W;

  logic [EW-1:0]                 mem [QUEUE_DEPTH];
  logic [EW-1:0]                 rd_data_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 idx_r;
  logic [CW-1:0]                 idx_p1;
  logic [CW-1:0]                 rd_sel;
  logic [ojq_pkg::KIND_W-1:0]    kind_r;
  logic [JW-1:0]                 job_r;
  logic [PW-1:0]                 proc_r;
  logic [JW-1:0]                 rem_job_r;
  logic [PW-1:0]                 rem_proc_r;
  logic [ojq_pkg::STAT_W-1:0]    status_r;
  logic [ojq_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [CW+FW-1:0]              count_ext;
  logic [JW-1:0]                 rd_job;
  logic [PW-1:0]                 rd_proc;

  assign idx_p1  = idx_r + CW'(1);
  assign rd_sel  = cmd.rd_next ? idx_p1 : idx_r;
  assign rd_job  = rd_data_r[JW-1:0];
  assign rd_proc = rd_data_r[EW-1:JW];

  assign sts.hit    = (kind_r == ojq_pkg::KIND_POP)    ? 1'b1 :
                      (kind_r == ojq_pkg::KIND_RM_JOB) ? (rd_job == job_r) :
                                                         (rd_proc == proc_r);
  assign sts.kind   = kind_r;
  assign sts.full   = (count_r == CW'(QUEUE_DEPTH));
  assign sts.empty  = (count_r == '0);
  assign sts.at_end = (idx_r == count_r);
  assign sts.last   = (idx_p1 >= count_r);

  always_ff @(posedge clk) begin
    if (cmd.app) begin
      mem[count_r[AW-1:0]] <= {proc_r, job_r};
    end else if (cmd.shift_wr) begin
      mem[idx_r[AW-1:0]] <= rd_data_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_sel[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clr) begin
      count_r <= '0;
    end else if (cmd.app) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end
    if (cmd.load) begin
      kind_r     <= in_kind;
      job_r      <= in_job_id;
      proc_r     <= in_proc_id;
      rem_job_r  <= '0;
      rem_proc_r <= '0;
      status_r   <= ojq_pkg::ST_NONE;
    end else begin
      if (cmd.hit_cap) begin
        rem_job_r  <= rd_job;
        rem_proc_r <= rd_proc;
      end
      if (cmd.st_set) begin
        status_r <= cmd.st_val;
      end
    end
  end

  assign count_ext = {{FW{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {2'b00, (count_r == '0), count_ext[FW-1:0], rem_proc_r, rem_job_r,
                     status_r};
    end
  end

  assign out_data = out_data_r;

endmodule

@@ rtl/ojq_ctrl.sv @@
// Sequencer of the ordered job queue: accepts items, steps the scan and
// close-up passes and owns the result valid flag. Depends on ojq_pkg.
module ojq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ojq_pkg::ojq_sts_t sts,
  output ojq_pkg::ojq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (sts.kind)
          ojq_pkg::KIND_APPEND: begin
            cmd.st_set = 1'b1;
            if (sts.full) begin
              cmd.st_val = ojq_pkg::ST_FULL;
            end else begin
              cmd.app    = 1'b1;
              cmd.st_val = ojq_pkg::ST_OK;
            end
            state_nxt = S_FINISH;
          end
          ojq_pkg::KIND_POP, ojq_pkg::KIND_RM_JOB, ojq_pkg::KIND_RM_PROC: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN_RD;
          end
          ojq_pkg::KIND_CLEAR: begin
            cmd.clr    = 1'b1;
            cmd.st_set = 1'b1;
            cmd.st_val = ojq_pkg::ST_OK;
            state_nxt  = S_FINISH;
          end
          default: begin
            cmd.st_set = 1'b1;
            cmd.st_val = ojq_pkg::ST_NONE;
            state_nxt  = S_FINISH;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (sts.at_end) begin
          cmd.st_set = 1'b1;
          cmd.st_val = ojq_pkg::ST_NONE;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.hit) begin
          cmd.hit_cap = 1'b1;
          state_nxt   = S_SHIFT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.last) begin
          cmd.dec    = 1'b1;
          cmd.st_set = 1'b1;
          cmd.st_val = ojq_pkg::ST_OK;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ verif/ojq_checker.sv @@
// Checker for the ordered job queue: watches the request and result streams,
// keeps its own copy of the queue, predicts each result and compares it.
// Depends on ojq_pkg for widths and operation/status codes.
module ojq_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ojq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ojq_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ojq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fails,
  output int                              pending,
  output int                              results,
  output int                              full_hits,
  output int                              key_hits,
  output int                              peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KW = ojq_pkg::KIND_W;
  localparam int unsigned JW = ojq_pkg::JOB_W;
  localparam int unsigned PW = ojq_pkg::PROC_W;
  localparam int unsigned SW = ojq_pkg::STAT_W;
  localparam int unsigned FW = ojq_pkg::FILL_W;

  typedef struct packed {
    logic [JW-1:0] job;
    logic [PW-1:0] proc;
  } job_entry_t;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [JW-1:0] job;
    logic [PW-1:0] proc;
    logic [FW-1:0] fill;
    logic          empty;
  } job_result_t;

  job_entry_t  job_list[$];
  job_result_t due_results[$];

  function automatic job_result_t apply_job_request(input logic [KW-1:0] kind,
                                                     input logic [JW-1:0] job,
                                                     input logic [PW-1:0] proc);
    job_result_t r;
    job_entry_t  e;
    int          pos;
    r = '0;
    r.status = ojq_pkg::ST_NONE;
    pos = -1;
    case (kind)
      ojq_pkg::KIND_APPEND: begin
        if (job_list.size() >= ojq_pkg::QUEUE_DEPTH) begin
          r.status = ojq_pkg::ST_FULL;
        end else begin
          e.job = job;
          e.proc = proc;
          job_list.push_back(e);
          r.status = ojq_pkg::ST_OK;
        end
      end
      ojq_pkg::KIND_POP: begin
        if (job_list.size() != 0) pos = 0;
      end
      ojq_pkg::KIND_RM_JOB: begin
        foreach (job_list[i]) if (pos < 0 && job_list[i].job == job) pos = i;
      end
      ojq_pkg::KIND_RM_PROC: begin
        foreach (job_list[i]) if (pos < 0 && job_list[i].proc == proc) pos = i;
      end
      ojq_pkg::KIND_CLEAR: begin
        job_list.delete();
        r.status = ojq_pkg::ST_OK;
      end
      default: ;
    endcase
    if (pos >= 0) begin
      e = job_list[pos];
      job_list.delete(pos);
      r.status = ojq_pkg::ST_OK;
      r.job = e.job;
      r.proc = e.proc;
    end
    r.fill = FW'(job_list.size());
    r.empty = (job_list.size() == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    job_result_t exp_r;
    job_result_t got_r;
    if (!rst_n) begin
      job_list.delete();
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results++;
        got_r.status = out_tdata[1:0];
        got_r.job    = out_tdata[17:2];
        got_r.proc   = out_tdata[39:18];
        got_r.fill   = out_tdata[44:40];
        got_r.empty  = out_tdata[45];
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          fails++;
        end else begin
          exp_r = due_results.pop_front();
          if (got_r.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, got_r.status);
            fails++;
          end
          if (got_r.job !== exp_r.job) begin
            $error("out_job_id expected %h got %h", exp_r.job, got_r.job);
            fails++;
          end
          if (got_r.proc !== exp_r.proc) begin
            $error("out_proc_id expected %h got %h", exp_r.proc, got_r.proc);
            fails++;
          end
          if (got_r.fill !== exp_r.fill) begin
            $error("fill_level expected %0d got %0d", exp_r.fill, got_r.fill);
            fails++;
          end
          if (got_r.empty !== exp_r.empty) begin
            $error("is_empty expected %0d got %0d", exp_r.empty, got_r.empty);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        exp_r = apply_job_request(in_tuser, in_tdata[JW-1:0], in_tdata[JW +: PW]);
        due_results.push_back(exp_r);
        if (exp_r.status == ojq_pkg::ST_FULL) full_hits++;
        if ((in_tuser == ojq_pkg::KIND_RM_JOB || in_tuser == ojq_pkg::KIND_RM_PROC) &&
            exp_r.status == ojq_pkg::ST_OK)
          key_hits++;
        if (job_list.size() > peak_fill) peak_fill = job_list.size();
      end
    end
    pending <= due_results.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the ordered job queue: clock, reset, request stimulus,
// receiver throttling, watchdog and verdict. Checking is done in ojq_checker.
// Depends on ojq_pkg, ojq_checker and ordered_job_queue_keyed_remove.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KW = ojq_pkg::KIND_W;
  localparam int unsigned JW = ojq_pkg::JOB_W;
  localparam int unsigned PW = ojq_pkg::PROC_W;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 450;
  localparam logic [KW-1:0] KIND_SPARE = ojq_pkg::KIND_CLEAR + 3'd1;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ojq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KW-1:0]                   in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ojq_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fails, pending, results, full_hits, key_hits, peak_fill;
  int src_pct = 0;
  int sink_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sent = 0;

  logic [JW-1:0] recent_job[8];
  logic [PW-1:0] recent_proc[8];
  logic [2:0]    recent_wr = '0;

  ordered_job_queue_keyed_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ojq_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fails      (fails),
    .pending    (pending),
    .results    (results),
    .full_hits  (full_hits),
    .key_hits   (key_hits),
    .peak_fill  (peak_fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL ordered_job_queue_keyed_remove");
      $finish;
    end
  end

  task automatic send_request(input logic [KW-1:0] kind, input logic [JW-1:0] job,
                              input logic [PW-1:0] proc);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(ojq_pkg::IN_TDATA_W - ojq_pkg::ENT_W){1'b0}}, proc, job};
    do @(posedge clk); while (!in_tready);
    if (kind == ojq_pkg::KIND_APPEND) begin
      recent_job[recent_wr] = job;
      recent_proc[recent_wr] = proc;
      recent_wr = recent_wr + 3'd1;
    end
    sent++;
  endtask

  // drop valid, then hold until every expected result has been taken
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [JW-1:0] pick_job();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return recent_job[3'($urandom_range(0, 7))];
    if (r < 65) return JW'($urandom_range(0, 7));
    if (r < 70) return '1;
    return JW'($urandom);
  endfunction

  function automatic logic [PW-1:0] pick_proc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return recent_proc[3'($urandom_range(0, 7))];
    if (r < 65) return PW'($urandom_range(0, 7));
    if (r < 70) return '1;
    return PW'($urandom);
  endfunction

  task automatic send_random(input int append_pct);
    int            roll;
    logic [KW-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < append_pct) kind = ojq_pkg::KIND_APPEND;
    else if (roll < 97) kind = KW'($urandom_range(ojq_pkg::KIND_POP, ojq_pkg::KIND_RM_PROC));
    else if (roll < 98) kind = ojq_pkg::KIND_CLEAR;
    else kind = ojq_pkg::KIND_CLEAR + KW'($urandom_range(1, 3));
    send_request(kind, pick_job(), pick_proc());
  endtask

  initial begin
    int ph;
    int n;
    foreach (recent_job[i]) begin
      recent_job[i] = '0;
      recent_proc[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ojq_pkg::KIND_CLEAR, '0, '0);
    send_request(ojq_pkg::KIND_POP, '0, '0);
    send_request(ojq_pkg::KIND_RM_JOB, '1, '0);
    send_request(ojq_pkg::KIND_RM_PROC, '0, '1);
    send_request(KIND_SPARE, JW'($urandom), PW'($urandom));
    send_request(KIND_SPARE + 3'd1, JW'($urandom), PW'($urandom));
    send_request(KIND_SPARE + 3'd2, JW'($urandom), PW'($urandom));
    send_request(ojq_pkg::KIND_APPEND, '0, '0);
    send_request(ojq_pkg::KIND_APPEND, '1, '1);
    send_request(ojq_pkg::KIND_APPEND, 16'h1234, '0);
    send_request(ojq_pkg::KIND_APPEND, '0, 22'h2a);
    send_request(ojq_pkg::KIND_RM_JOB, '0, '1);
    send_request(ojq_pkg::KIND_RM_PROC, '1, '0);
    send_request(ojq_pkg::KIND_RM_JOB, 16'h7777, '0);
    send_request(ojq_pkg::KIND_RM_PROC, '0, 22'h12345);
    send_request(ojq_pkg::KIND_POP, '0, '0);
    send_request(ojq_pkg::KIND_POP, '0, '0);
    send_request(ojq_pkg::KIND_POP, '0, '0);
    send_request(ojq_pkg::KIND_APPEND, 16'h00ff, 22'h155555);
    send_request(ojq_pkg::KIND_APPEND, 16'hff00, 22'h2aaaaa);
    send_request(ojq_pkg::KIND_CLEAR, '0, '0);
    send_request(ojq_pkg::KIND_POP, '0, '0);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_pct = 0;  sink_pct = 0;  end
        1: begin src_pct = 62; sink_pct = 0;  end
        2: begin src_pct = 0;  sink_pct = 62; end
        default: begin src_pct = 22; sink_pct = 22; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random(((n / 40) % 2 == 0) ? 75 : 25);
        if (ph == 0 && n == 200) hold_ask++;
        if (n % 150 == 149) drain();
      end
      drain();
    end
    repeat (2 * ojq_pkg::QUEUE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results over four throttling phases.",
             sent, results);
    $display("Full appends %0d, keyed removals that hit %0d, peak fill %0d.",
             full_hits, key_hits, peak_fill);
    if (fails == 0 && pending == 0) begin
      $display("PASS ordered_job_queue_keyed_remove");
    end else begin
      $display("FAIL ordered_job_queue_keyed_remove");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ojq_pkg.sv
rtl/ojq_dp.sv
rtl/ojq_ctrl.sv
rtl/ordered_job_queue_keyed_remove.sv
verif/ojq_checker.sv
verif/tb.sv
